@@ sv/dsfo_pkg.sv @@
// Shared types and codes for the no-duplicate stack with forget-old policy.
package dsfo_pkg;

  // Operation selector carried in the input item
  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_NEW   = 2'd0;
  localparam logic [1:0] ST_DUP   = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  localparam int unsigned CAP_BITS   = 5;
  localparam int unsigned COUNT_BITS = 5;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] item_value;
  } in_item_t;

  typedef struct packed {
    logic                  accepted;
    logic [1:0]            status;
    logic signed [31:0]    popped_value;
    logic [COUNT_BITS-1:0] item_count;
  } out_item_t;

  // Broadcast to every cell for one accepted item
  typedef struct packed {
    logic dup_move;   // close the gap above the match, new value to top
    logic push_new;   // write new value just above current top
  } cell_ctl_t;

endpackage

@@ sv/dsfo_cell.sv @@
// One storage cell of the stack: holds an entry, compares it, shifts from above.
module dsfo_cell
  import dsfo_pkg::*;
#(
  parameter int unsigned INDEX     = 0,
  parameter int unsigned CW        = 5,
  parameter int unsigned ITEM_BITS = 32
) (
  input  logic                 clk,
  input  cell_ctl_t            ctl,
  input  logic [CW-1:0]        count,
  input  logic [CW-1:0]        pos,
  input  logic [ITEM_BITS-1:0] new_val,
  input  logic [ITEM_BITS-1:0] up_entry,
  output logic [ITEM_BITS-1:0] entry,
  output logic                 hit
);

  localparam logic [CW:0] IDX  = (CW+1)'(INDEX);
  localparam logic [CW:0] IDX1 = (CW+1)'(INDEX + 1);

  logic [ITEM_BITS-1:0] entry_r;
  logic [ITEM_BITS-1:0] entry_nxt;
  logic                 shift_en;
  logic                 load_en;

  assign entry = entry_r;
  assign hit   = (IDX < {1'b0, count}) && (entry_r == new_val);

  assign shift_en = ctl.dup_move && (IDX >= {1'b0, pos}) && (IDX1 < {1'b0, count});
  assign load_en  = (ctl.dup_move && (IDX1 == {1'b0, count})) ||
                    (ctl.push_new && (IDX == {1'b0, count}));

  always_comb begin
    entry_nxt = entry_r;
    if (shift_en) begin
      entry_nxt = up_entry;
    end else if (load_en) begin
      entry_nxt = new_val;
    end
  end

  // Payload only: no reset
  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

@@ sv/dedup_stack_forget_old.sv @@
// A result item is written into the output register in the cycle after its item is accepted.
// Throughput: one item per cycle unless stalled; all cells compare and shift in the same cycle.
// The output register lets a new item in while the last result waits, unless out_stall holds it.
// Reset: count cleared, capacity set to 16, output empty; cell entries are not cleared.
// Only entries below the count are ever read, so stale cell contents never reach a result.
module dedup_stack_forget_old
  import dsfo_pkg::*;
#(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned ITEM_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_item_t            in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output out_item_t           out_item,
  input  logic                cfg_we,
  input  logic [CAP_BITS-1:0] cfg_wdata
);

  // Count width holds 0..DEPTH; index width addresses the cells
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned EW = (CW > CAP_BITS) ? CW : CAP_BITS;

  logic [CW-1:0]       count_r, count_nxt;
  logic [CAP_BITS-1:0] cap_r, cap_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_item_r, out_item_nxt;

  logic                 fire;
  logic [CW-1:0]        cap_eff;
  logic [63:0]          in_wide;
  logic [ITEM_BITS-1:0] new_val;
  logic [ITEM_BITS-1:0] ent [DEPTH];
  logic [ITEM_BITS-1:0] up  [DEPTH];
  logic [DEPTH-1:0]     hit;
  logic                 any_hit;
  logic [CW-1:0]        pos;
  logic [IW-1:0]        top_idx;
  logic [63:0]          top_wide;
  logic [31:0]          count_wide;
  cell_ctl_t            ctl;

  // Accept while the output register is free or being drained
  assign in_stall  = out_valid_r && out_stall;
  assign fire      = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Compare on the low ITEM_BITS bits of the pushed value
  assign in_wide = {32'b0, in_item.item_value};
  assign new_val = in_wide[ITEM_BITS-1:0];

  // Clamp capacity to the built depth
  assign cap_eff = (EW'(cap_r) > EW'(DEPTH)) ? CW'(DEPTH) : CW'(cap_r);

  // Row of cells; each one takes its upper neighbor's entry when the gap closes
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == DEPTH - 1) begin : g_top
      assign up[i] = '0;
    end else begin : g_mid
      assign up[i] = ent[i+1];
    end

    dsfo_cell #(
      .INDEX     (i),
      .CW        (CW),
      .ITEM_BITS (ITEM_BITS)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .count    (count_r),
      .pos      (pos),
      .new_val  (new_val),
      .up_entry (up[i]),
      .entry    (ent[i]),
      .hit      (hit[i])
    );
  end

  // Stored items are distinct, so at most one cell hits; encode its place
  always_comb begin
    pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      pos = pos | (hit[i] ? CW'(i) : '0);
    end
  end
  assign any_hit = |hit;

  // Top entry for a pop (only read when the count is nonzero)
  assign top_idx  = IW'(count_r - CW'(1));
  assign top_wide = 64'(ent[top_idx]);

  always_comb begin
    ctl           = '0;
    count_nxt     = count_r;
    cap_nxt       = cfg_we ? cfg_wdata : cap_r;
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_stall ? out_valid_r : 1'b0;
    count_wide    = '0;

    if (fire) begin
      out_item_nxt.accepted     = 1'b0;
      out_item_nxt.status       = ST_NEW;
      out_item_nxt.popped_value = '0;
      if (in_item.mode == MODE_PUSH) begin
        if (any_hit) begin
          // Drop the old copy, shift the upper part down, new value on top
          ctl.dup_move          = 1'b1;
          out_item_nxt.accepted = 1'b1;
          out_item_nxt.status   = ST_DUP;
        end else if (count_r < cap_eff) begin
          ctl.push_new          = 1'b1;
          count_nxt             = count_r + CW'(1);
          out_item_nxt.accepted = 1'b1;
          out_item_nxt.status   = ST_NEW;
        end else begin
          out_item_nxt.status = ST_FULL;
        end
      end else begin
        if (count_r != '0) begin
          count_nxt                 = count_r - CW'(1);
          out_item_nxt.accepted     = 1'b1;
          out_item_nxt.status       = ST_NEW;
          out_item_nxt.popped_value = top_wide[31:0];
        end else begin
          out_item_nxt.status = ST_EMPTY;
        end
      end
      count_wide              = 32'(count_nxt);
      out_item_nxt.item_count = count_wide[COUNT_BITS-1:0];
      out_valid_nxt           = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload: hold while stalled, no reset
  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

endmodule
